// ===== sv/epoch_seconds_to_calendar_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the epoch-to-calendar core
// Shared by every module that checks its own pipeline.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH

// Checked on every rising edge outside reset
`define ESC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define ESC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Constants, types and tables for the epoch-to-calendar pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    // Seconds are biased so that every input becomes a positive count:
    // (t + 2^31) + BIAS_ADD = t + 24856 * 86400
    localparam logic [32:0] BIAS_ADD = 33'd74752;

    // 86400 = 128 * 675: low seven bits pass straight, the rest divides by 675
    localparam int          LO_BITS      = 7;
    localparam logic [9:0]  DIV_675      = 10'd675;
    localparam logic [26:0] RECIP_675    = 27'd101806632;   // floor(2^36 / 675)

    // Day count since 1900-01-01 = biased day + 712
    localparam logic [15:0] DAY_BIAS     = 16'd712;

    localparam logic [10:0] DAYS_CYCLE   = 11'd1461;
    localparam logic [15:0] RECIP_1461   = 16'd45934;       // ceil(2^26 / 1461)
    localparam logic [10:0] DAYS_LEAP_YR = 11'd366;
    localparam logic [10:0] DAYS_YR      = 11'd365;
    localparam logic [10:0] DAYS_TWO_YR  = 11'd730;

    localparam logic [11:0] SECS_HOUR    = 12'd3600;
    localparam logic [12:0] RECIP_225    = 13'd4661;        // ceil(2^20 / 225)
    localparam logic [5:0]  SECS_MIN     = 6'd60;
    localparam logic [10:0] RECIP_15     = 11'd1093;        // ceil(2^14 / 15)

    localparam int          MONTHS       = 12;
    localparam logic [2:0]  DAYS_WEEK    = 3'd7;

    typedef struct packed {
        logic [7:0] year_since_1900;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [8:0] day_of_year;
    } t_date;

    // First day of year of each month
    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (mon >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== sv/esc_date_split.sv =====
// ----------------------------------------------------------------------------
// esc_date_split
// Five-stage pipeline from a day count since 1900 to year, month, day of
// month and day of year under the every-fourth-year leap rule.
// ----------------------------------------------------------------------------
`default_nettype none
`include "epoch_seconds_to_calendar_core_defines.svh"

module esc_date_split (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [15:0]    i_day,
    output logic           o_valid,
    output esc_pkg::t_date o_date
);
    import esc_pkg::*;

    // stage valids
    logic [4:0]  r_v;
    logic [4:0]  n_v;

    // stage 1: four-year cycle estimate
    logic [31:0] w_cyc_prod;
    logic [5:0]  r_d1_cyc;
    logic [15:0] r_d1_day;

    // stage 2: day within cycle
    logic [15:0] w_cyc_days;
    logic [15:0] w_cyc_rem;
    logic [10:0] r_d2_rem;
    logic [5:0]  r_d2_cyc;

    // stage 3: year and day of year
    logic [10:0] w_rem2;
    logic [1:0]  w_yoff;
    logic [10:0] w_yday;
    logic [8:0]  r_d3_yday;
    logic [7:0]  r_d3_year;
    logic        r_d3_leap;

    // stage 4: month
    logic [3:0]  n_mon;
    logic [3:0]  r_d4_mon;
    logic [8:0]  r_d4_yday;
    logic [7:0]  r_d4_year;
    logic        r_d4_leap;

    // stage 5: output
    logic [8:0]  w_dom;
    t_date       r_date;

    assign n_v = {r_v[3:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign w_cyc_prod = 32'(i_day) * 32'(RECIP_1461);

    always_ff @(posedge i_clk) begin
        r_d1_cyc <= w_cyc_prod[31:26];
        r_d1_day <= i_day;
    end

    assign w_cyc_days = 16'(r_d1_cyc) * 16'(DAYS_CYCLE);
    assign w_cyc_rem  = r_d1_day - w_cyc_days;

    always_ff @(posedge i_clk) begin
        r_d2_rem <= w_cyc_rem[10:0];
        r_d2_cyc <= r_d1_cyc;
    end

    // first year of the cycle is the leap year
    always_comb begin
        w_rem2 = r_d2_rem - DAYS_LEAP_YR;
        if (r_d2_rem < DAYS_LEAP_YR) begin
            w_yoff = 2'd0;
            w_yday = r_d2_rem;
        end else if (w_rem2 >= DAYS_TWO_YR) begin
            w_yoff = 2'd3;
            w_yday = w_rem2 - DAYS_TWO_YR;
        end else if (w_rem2 >= DAYS_YR) begin
            w_yoff = 2'd2;
            w_yday = w_rem2 - DAYS_YR;
        end else begin
            w_yoff = 2'd1;
            w_yday = w_rem2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d3_yday <= w_yday[8:0];
        r_d3_year <= {r_d2_cyc, w_yoff};
        r_d3_leap <= (w_yoff == 2'd0);
    end

    // count the month starts already passed
    always_comb begin
        n_mon = '0;
        for (int m = 1; m < MONTHS; m++) begin
            if (r_d3_yday >= month_start(4'(m), r_d3_leap)) begin
                n_mon = n_mon + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d4_mon  <= n_mon;
        r_d4_yday <= r_d3_yday;
        r_d4_year <= r_d3_year;
        r_d4_leap <= r_d3_leap;
    end

    assign w_dom = r_d4_yday - month_start(r_d4_mon, r_d4_leap) + 9'd1;

    always_ff @(posedge i_clk) begin
        r_date.year_since_1900 <= r_d4_year;
        r_date.month           <= r_d4_mon;
        r_date.day_of_month    <= w_dom[4:0];
        r_date.day_of_year     <= r_d4_yday;
    end

    assign o_valid = r_v[4];
    assign o_date  = r_date;

    `ESC_ASSERT(a_cyc_rem, r_v[1] |-> (r_d2_rem < DAYS_CYCLE), "cycle remainder out of range")
    `ESC_ASSERT(a_leap_day, o_valid |-> ((o_date.day_of_year != 9'd365) || (o_date.year_since_1900[1:0] == 2'd0)), "day 365 in a common year")
    `ESC_ASSERT(a_date_rng, o_valid |-> ((o_date.day_of_month != 5'd0) && (o_date.month < 4'd12) && (o_date.year_since_1900 != 8'd0) && (o_date.year_since_1900 <= 8'd138)), "date field out of range")

endmodule

`default_nettype wire

// ===== sv/epoch_seconds_to_calendar_core.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Nine-stage pipeline that breaks a signed Unix time into UTC calendar fields.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_epoch_seconds and raise start for one cycle per item; an item is
//   taken at every rising edge where start is high and busy is low. busy
//   stays low, so a new item may enter on every cycle.
//   Each result appears on the o_* field ports for exactly one cycle with
//   o_valid high; results leave in input order. Throughput is one item per
//   cycle. The pipeline is a chain of reciprocal multiplies: day split by
//   675 with a one-step correction, then the four-year cycle split and the
//   hour/minute split, each multiply followed by a register.
//   The receiver cannot stall, so results are never held back.
//   Reset (synchronous, active low) clears all stage valid bits; items in
//   flight are dropped and no result is shown until a new transfer in.
//   The block keeps no state between items and has no configuration.
// ----------------------------------------------------------------------------
`default_nettype none
`include "epoch_seconds_to_calendar_core_defines.svh"

module epoch_seconds_to_calendar_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [7:0]  o_year_since_1900,
    output logic [2:0]  o_weekday,
    output logic [8:0]  o_day_of_year
);
    import esc_pkg::*;

    logic        w_accept;
    logic [3:0]  r_v;
    logic [3:0]  n_v;

    // stage 1: bias
    logic [32:0] w_biased;
    logic [25:0] r_s1_x;
    logic [6:0]  r_s1_lo;

    // stage 2: day estimate
    logic [52:0] w_q_prod;
    logic [15:0] r_s2_q0;
    logic [25:0] r_s2_x;
    logic [6:0]  r_s2_lo;

    // stage 3: remainder of the estimate
    logic [25:0] w_q_back;
    logic [25:0] w_q_rem;
    logic [10:0] r_s3_r0;
    logic [15:0] r_s3_q0;
    logic [6:0]  r_s3_lo;

    // stage 4: corrected day and time of day
    logic        w_fix;
    logic [10:0] w_r_fix;
    logic [15:0] n_day;
    logic [15:0] r_s4_day;
    logic [16:0] r_s4_hms;

    // stage 5: hour and weekday
    logic [25:0] w_h_prod;
    logic [5:0]  w_oct_sum;
    logic [3:0]  w_oct_fold;
    logic [2:0]  n_wday;
    logic [4:0]  r_s5_hour;
    logic [16:0] r_s5_hms;
    logic [2:0]  r_s5_wday;

    // stage 6: seconds within hour
    logic [16:0] w_h_back;
    logic [16:0] w_h_rem;
    logic [11:0] r_s6_remh;
    logic [4:0]  r_s6_hour;
    logic [2:0]  r_s6_wday;

    // stage 7: minute
    logic [20:0] w_m_prod;
    logic [5:0]  r_s7_min;
    logic [11:0] r_s7_remh;
    logic [4:0]  r_s7_hour;
    logic [2:0]  r_s7_wday;

    // stage 8: second
    logic [11:0] w_m_back;
    logic [11:0] w_s_rem;
    logic [5:0]  r_s8_sec;
    logic [5:0]  r_s8_min;
    logic [4:0]  r_s8_hour;
    logic [2:0]  r_s8_wday;

    // stage 9: output
    logic [5:0]  r_s9_sec;
    logic [5:0]  r_s9_min;
    logic [4:0]  r_s9_hour;
    logic [2:0]  r_s9_wday;

    logic        w_date_valid;
    t_date       w_date;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign n_v      = {r_v[2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // flip the sign bit, then add the rest of the bias
    assign w_biased = {1'b0, i_epoch_seconds ^ 32'h8000_0000} + BIAS_ADD;

    always_ff @(posedge i_clk) begin
        r_s1_x  <= w_biased[32:LO_BITS];
        r_s1_lo <= w_biased[LO_BITS-1:0];
    end

    assign w_q_prod = 53'(r_s1_x) * 53'(RECIP_675);

    always_ff @(posedge i_clk) begin
        r_s2_q0 <= w_q_prod[51:36];
        r_s2_x  <= r_s1_x;
        r_s2_lo <= r_s1_lo;
    end

    assign w_q_back = 26'(r_s2_q0) * 26'(DIV_675);
    assign w_q_rem  = r_s2_x - w_q_back;

    always_ff @(posedge i_clk) begin
        r_s3_r0 <= w_q_rem[10:0];
        r_s3_q0 <= r_s2_q0;
        r_s3_lo <= r_s2_lo;
    end

    // estimate runs at most one low
    assign w_fix   = (r_s3_r0 >= 11'(DIV_675));
    assign w_r_fix = w_fix ? (r_s3_r0 - 11'(DIV_675)) : r_s3_r0;
    assign n_day   = r_s3_q0 + 16'(w_fix) + DAY_BIAS;

    always_ff @(posedge i_clk) begin
        r_s4_day <= n_day;
        r_s4_hms <= {w_r_fix[9:0], r_s3_lo};
    end

    // hour = (hms / 16) / 225
    assign w_h_prod = 26'(r_s4_hms[16:4]) * 26'(RECIP_225);

    // day since 1900 mod 7 is the weekday; fold octal digits since 8 = 1 mod 7
    assign w_oct_sum = 6'(r_s4_day[2:0]) + 6'(r_s4_day[5:3]) + 6'(r_s4_day[8:6])
                     + 6'(r_s4_day[11:9]) + 6'(r_s4_day[14:12]) + 6'(r_s4_day[15]);
    assign w_oct_fold = 4'(w_oct_sum[5:3]) + 4'(w_oct_sum[2:0]);
    assign n_wday = (w_oct_fold >= 4'(DAYS_WEEK)) ? 3'(w_oct_fold - 4'(DAYS_WEEK))
                                                  : w_oct_fold[2:0];

    always_ff @(posedge i_clk) begin
        r_s5_hour <= w_h_prod[24:20];
        r_s5_hms  <= r_s4_hms;
        r_s5_wday <= n_wday;
    end

    assign w_h_back = 17'(r_s5_hour) * 17'(SECS_HOUR);
    assign w_h_rem  = r_s5_hms - w_h_back;

    always_ff @(posedge i_clk) begin
        r_s6_remh <= w_h_rem[11:0];
        r_s6_hour <= r_s5_hour;
        r_s6_wday <= r_s5_wday;
    end

    // minute = (rem / 4) / 15
    assign w_m_prod = 21'(r_s6_remh[11:2]) * 21'(RECIP_15);

    always_ff @(posedge i_clk) begin
        r_s7_min  <= w_m_prod[19:14];
        r_s7_remh <= r_s6_remh;
        r_s7_hour <= r_s6_hour;
        r_s7_wday <= r_s6_wday;
    end

    assign w_m_back = 12'(r_s7_min) * 12'(SECS_MIN);
    assign w_s_rem  = r_s7_remh - w_m_back;

    always_ff @(posedge i_clk) begin
        r_s8_sec  <= w_s_rem[5:0];
        r_s8_min  <= r_s7_min;
        r_s8_hour <= r_s7_hour;
        r_s8_wday <= r_s7_wday;
    end

    always_ff @(posedge i_clk) begin
        r_s9_sec  <= r_s8_sec;
        r_s9_min  <= r_s8_min;
        r_s9_hour <= r_s8_hour;
        r_s9_wday <= r_s8_wday;
    end

    // date path runs alongside the time path and lines up at the output
    esc_date_split u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[3]),
        .i_day   (r_s4_day),
        .o_valid (w_date_valid),
        .o_date  (w_date)
    );

    assign o_valid           = w_date_valid;
    assign o_second          = r_s9_sec;
    assign o_minute          = r_s9_min;
    assign o_hour            = r_s9_hour;
    assign o_weekday         = r_s9_wday;
    assign o_day_of_month    = w_date.day_of_month;
    assign o_month           = w_date.month;
    assign o_year_since_1900 = w_date.year_since_1900;
    assign o_day_of_year     = w_date.day_of_year;

    `ESC_ASSERT(a_day_est, r_v[2] |-> (r_s3_r0 < 11'd1350), "day estimate off by more than one")
    `ESC_ASSERT(a_time_rng, o_valid |-> ((o_hour < 5'd24) && (o_minute < 6'd60) && (o_second < 6'd60)), "time of day out of range")
    `ESC_ASSERT(a_wday_rng, o_valid |-> (o_weekday < 3'd7), "weekday out of range")
    `ESC_ASSERT_ALWAYS(a_rst_flush, !i_rst_n |=> (r_v == 4'd0), "reset left a stage valid")

endmodule

`default_nettype wire
